/* rtl/mac_learning_forward_table_assert.svh */
// Assertion macros shared by the learning table RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef MAC_LEARNING_FORWARD_TABLE_ASSERT_SVH
`define MAC_LEARNING_FORWARD_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MLFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mlft_pkg.sv */
// Package for the MAC learning forwarding table: item types and register codes.
// Used by the top module of the block; depends on nothing.
`timescale 1ns / 1ps

package mlft_pkg;

  localparam int unsigned MAC_W     = 48;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE_TIMEOUT = 2'd0,
    CFG_HARD_TIMEOUT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]       switch_id;
    logic [MAC_W-1:0] src_mac;
    logic [MAC_W-1:0] dst_mac;
    logic [7:0]       in_port;
    logic [15:0]      ethertype;
  } in_item_t;

  typedef struct packed {
    logic             forward;
    logic [7:0]       out_port;
    logic [TMO_W-1:0] rule_idle_timeout;
    logic [TMO_W-1:0] rule_hard_timeout;
    logic             learned_new;
    logic             table_full;
  } out_item_t;

endpackage

/* rtl/mlft_table_mem.sv */
// Single-port synchronous table memory holding {key, port} per entry.
// Read data is registered and appears in the cycle after rd_en_i; no package dependency.
`timescale 1ns / 1ps

module mlft_table_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mac_learning_forward_table.sv */
// MAC learning forwarding table. Once an item is accepted, the single memory port
// scans the stored entries one per cycle, comparing each with both the source and
// destination key; then the source is learned if new and there is room, and the
// result is issued when the output is free. Only one item is in work at a time;
// the next item can be taken in the cycle after the result is issued, and a new item
// is taken while a result waits. Reset (rst_ni low, asynchronous) empties the table by
// clearing the fill count and zeroes both timeout registers; no clearing pass.
`timescale 1ns / 1ps

module mac_learning_forward_table #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned SWITCH_BITS   = 8,
  parameter int unsigned PORT_BITS     = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  mlft_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output mlft_pkg::out_item_t                out_item_o,
  input  logic                               cfg_we_i,
  input  logic [mlft_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mlft_pkg::CFG_DAT_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KW = SWITCH_BITS + mlft_pkg::MAC_W;
  localparam int unsigned EW = KW + PORT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LEARN,
    ST_RESP
  } state_e;

  state_e                   state_q;
  logic [KW-1:0]            src_key_q;
  logic [KW-1:0]            dst_key_q;
  logic [PORT_BITS-1:0]     port_q;
  logic [PORT_BITS-1:0]     dst_port_q;
  logic [CW-1:0]            idx_q;
  logic [CW-1:0]            fill_q;
  logic                     rd_pend_q;
  logic                     src_hit_q;
  logic                     dst_hit_q;
  logic                     learned_q;
  logic                     full_q;
  logic                     out_valid_q;
  mlft_pkg::out_item_t      out_q;
  logic [mlft_pkg::TMO_W-1:0] idle_tmo_q;
  logic [mlft_pkg::TMO_W-1:0] hard_tmo_q;

  logic                     accept;
  logic                     issue;
  logic                     room;
  logic                     learn;
  logic                     out_free;
  logic                     mem_rd;
  logic                     mem_we;
  logic [AW-1:0]            mem_addr;
  logic [EW-1:0]            mem_wdata;
  logic [EW-1:0]            mem_rdata;
  logic [KW-1:0]            rd_key;
  logic [PORT_BITS-1:0]     rd_port;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == ST_SCAN) && (idx_q < fill_q);
  assign room       = (fill_q < CW'(TABLE_ENTRIES));
  assign learn      = (state_q == ST_LEARN) && !src_hit_q && room;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign mem_rd    = issue;
  assign mem_we    = learn;
  assign mem_addr  = learn ? fill_q[AW-1:0] : idx_q[AW-1:0];
  assign mem_wdata = {src_key_q, port_q};
  assign rd_key    = mem_rdata[EW-1:PORT_BITS];
  assign rd_port   = mem_rdata[PORT_BITS-1:0];

  mlft_table_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (EW)
  ) u_table_mem (
    .clk_i   (clk_i),
    .rd_en_i (mem_rd),
    .wr_en_i (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_tmo_q <= '0;
      hard_tmo_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlft_pkg::CFG_IDLE_TIMEOUT: idle_tmo_q <= cfg_wdata_i;
        mlft_pkg::CFG_HARD_TIMEOUT: hard_tmo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_key_q   <= '0;
      dst_key_q   <= '0;
      port_q      <= '0;
      dst_port_q  <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      rd_pend_q   <= 1'b0;
      src_hit_q   <= 1'b0;
      dst_hit_q   <= 1'b0;
      learned_q   <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (!out_stall_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            src_key_q <= {SWITCH_BITS'(in_item_i.switch_id), in_item_i.src_mac};
            dst_key_q <= {SWITCH_BITS'(in_item_i.switch_id), in_item_i.dst_mac};
            port_q    <= PORT_BITS'(in_item_i.in_port);
            idx_q     <= '0;
            rd_pend_q <= 1'b0;
            src_hit_q <= 1'b0;
            dst_hit_q <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Reads are pipelined: the entry issued last cycle is compared now.
          rd_pend_q <= issue;
          if (issue) begin
            idx_q <= idx_q + CW'(1);
          end
          if (rd_pend_q) begin
            if (rd_key == src_key_q) begin
              src_hit_q <= 1'b1;
            end
            if (rd_key == dst_key_q) begin
              dst_hit_q  <= 1'b1;
              dst_port_q <= rd_port;
            end
          end
          if (!issue && !rd_pend_q) begin
            state_q <= ST_LEARN;
          end
        end
        ST_LEARN: begin
          learned_q <= learn;
          full_q    <= !src_hit_q && !room;
          if (learn) begin
            fill_q <= fill_q + CW'(1);
            // A source stored just now is already visible to the lookup.
            if (!dst_hit_q && (dst_key_q == src_key_q)) begin
              dst_hit_q  <= 1'b1;
              dst_port_q <= port_q;
            end
          end
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_q.forward           <= dst_hit_q;
            out_q.out_port          <= dst_hit_q ? 8'(dst_port_q) : '0;
            out_q.rule_idle_timeout <= dst_hit_q ? idle_tmo_q : '0;
            out_q.rule_hard_timeout <= dst_hit_q ? hard_tmo_q : '0;
            out_q.learned_new       <= learned_q;
            out_q.table_full        <= full_q;
            out_valid_q             <= 1'b1;
            state_q                 <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `include "mac_learning_forward_table_assert.svh"

  `MLFT_ASSERT_NEXT(a_fill_only_in_learn, state_q != ST_LEARN, $stable(fill_q), "fill count changed outside learn")
  `MLFT_ASSERT_NOW(a_learn_xor_full, out_valid_o, !(out_item_o.learned_new && out_item_o.table_full), "learned and full together")
  `MLFT_ASSERT_NOW(a_flood_zero, out_valid_o && !out_item_o.forward, (out_item_o.out_port == '0) && (out_item_o.rule_idle_timeout == '0) && (out_item_o.rule_hard_timeout == '0), "flood result carries nonzero fields")
  `MLFT_ASSERT_NOW(a_full_means_max, out_valid_o && out_item_o.table_full, fill_q == CW'(TABLE_ENTRIES), "table full reported below capacity")

endmodule
